[hw/rtl/rmsd_pkg.sv]
// ----------------------------------------------------------------------------
// Running mean plus standard deviation: shared package
// Widths, reset constants and the command and status words that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package rmsd_pkg;

  // Sample format and derived widths.
  localparam int unsigned SAMPLE_W  = 32;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned COUNT_W   = 32;
  localparam int unsigned SUM_W     = 2 * SAMPLE_W;
  localparam int unsigned ROOT_W    = SUM_W / 2;
  localparam int unsigned STEP_W    = $clog2(SUM_W + 1);

  // Reset mean is one millisecond in the sample format.
  localparam logic [SAMPLE_W-1:0] MEAN_RESET =
    SAMPLE_W'((64'd1 << FRAC_BITS) / 1000);
  localparam logic [SAMPLE_W-1:0] VALUE_MAX = '1;
  localparam logic [COUNT_W-1:0]  COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0]  COUNT_ONE = COUNT_W'(1);

  // Iteration counts of the serial units.
  localparam logic [STEP_W-1:0] DIV_STEPS_MEAN = STEP_W'(SAMPLE_W);
  localparam logic [STEP_W-1:0] DIV_STEPS_VAR  = STEP_W'(SUM_W);
  localparam logic [STEP_W-1:0] SQRT_STEPS     = STEP_W'(ROOT_W);

  // One-cycle commands from the controller to the datapath.
  typedef struct packed {
    logic cfg_load;  // reload state from the written register
    logic load;      // capture a sample and bump the count
    logic delta;     // register sample minus old mean
    logic div_mean;  // start delta / count
    logic mean;      // apply the mean step
    logic dev;       // register sample minus new mean
    logic mul;       // register the product of both deviations
    logic sum;       // update the squared deviation sum
    logic div_var;   // start sum / (count - 1)
    logic sqrt;      // start the square root
    logic result;    // write the output word
  } rmsd_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic div_busy;
    logic sqrt_busy;
  } rmsd_sts_t;

endpackage

[hw/rtl/rmsd_if.sv]
// ----------------------------------------------------------------------------
// Running mean plus standard deviation: channel interfaces
// Valid/ready channels for samples, results and the configuration register.
// ----------------------------------------------------------------------------
interface rmsd_sample_if import rmsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rmsd_result_if import rmsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] estimate;
  logic [COUNT_W-1:0]  sample_count;

  modport source (output valid, output estimate, output sample_count, input ready);
  modport sink (input valid, input estimate, input sample_count, output ready);
endinterface

interface rmsd_cfg_if import rmsd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] initial_mean;

  modport source (output valid, output initial_mean, input ready);
  modport sink (input valid, input initial_mean, output ready);
endinterface

[hw/rtl/rmsd_div.sv]
// ----------------------------------------------------------------------------
// Running mean plus standard deviation: serial divider
// Restoring unsigned divider, one quotient bit per cycle. The dividend is
// left aligned; after N steps the low N bits hold the quotient.
// ----------------------------------------------------------------------------
module rmsd_div import rmsd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [STEP_W-1:0]  steps_i,
  input  logic [SUM_W-1:0]   dividend_i,
  input  logic [COUNT_W-1:0] divisor_i,
  output logic               busy_o,
  output logic [SUM_W-1:0]   quotient_o
);

  logic [STEP_W-1:0]  cnt_q;
  logic [COUNT_W-1:0] rem_q;
  logic [COUNT_W-1:0] dvs_q;
  logic [SUM_W-1:0]   quo_q;
  logic [COUNT_W:0]   trial;
  logic [COUNT_W:0]   diff;
  logic               fits;

  assign busy_o     = (cnt_q != '0);
  assign quotient_o = quo_q;

  // Shift in the next dividend bit and try to subtract the divisor.
  always_comb begin
    trial = {rem_q, quo_q[SUM_W-1]};
    diff  = trial - {1'b0, dvs_q};
    fits  = (trial >= {1'b0, dvs_q});
  end

  // Iteration counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= steps_i;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_o) begin
      rem_q <= fits ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
      quo_q <= {quo_q[SUM_W-2:0], fits};
    end
  end

endmodule

[hw/rtl/rmsd_sqrt.sv]
// ----------------------------------------------------------------------------
// Running mean plus standard deviation: serial square root
// Restoring integer square root, one root bit per cycle, giving the floor.
// ----------------------------------------------------------------------------
module rmsd_sqrt import rmsd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [SUM_W-1:0]  radicand_i,
  output logic              busy_o,
  output logic [ROOT_W-1:0] root_o
);

  localparam int unsigned REM_W = ROOT_W + 2;

  logic [STEP_W-1:0] cnt_q;
  logic [SUM_W-1:0]  rad_q;
  logic [REM_W-1:0]  rem_q;
  logic [ROOT_W-1:0] root_q;
  logic [REM_W+1:0]  acc;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              fits;

  assign busy_o = (cnt_q != '0);
  assign root_o = root_q;

  // Bring down two radicand bits and test root*4 + 1 against them.
  always_comb begin
    acc   = {rem_q, rad_q[SUM_W-1 -: 2]};
    trial = (REM_W + 2)'({root_q, 2'b01});
    diff  = acc - trial;
    fits  = (acc >= trial);
  end

  // Iteration counter.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= SQRT_STEPS;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  // Partial remainder, root and radicand shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_o) begin
      rad_q  <= {rad_q[SUM_W-3:0], 2'b00};
      rem_q  <= fits ? diff[REM_W-1:0] : acc[REM_W-1:0];
      root_q <= {root_q[ROOT_W-2:0], fits};
    end
  end

endmodule

[hw/rtl/rmsd_dp.sv]
// ----------------------------------------------------------------------------
// Running mean plus standard deviation: datapath
// Holds the running state and carries out the Welford update one command at
// a time, with a shared serial divider and a serial square root unit.
// ----------------------------------------------------------------------------
module rmsd_dp import rmsd_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  rmsd_cmd_t           cmd_i,
  output rmsd_sts_t           sts_o,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic [SAMPLE_W-1:0] cfg_data_i,
  output logic [SAMPLE_W-1:0] estimate_o,
  output logic [COUNT_W-1:0]  sample_count_o
);

  // Running state.
  logic [SAMPLE_W-1:0] mean_q;
  logic [SUM_W-1:0]    sum_q;
  logic [COUNT_W-1:0]  count_q;

  // Working registers.
  logic [SAMPLE_W-1:0] smp_q;
  logic                neg_q;
  logic [SAMPLE_W-1:0] mag_q;
  logic                dneg_q;
  logic [SAMPLE_W-1:0] dmag_q;
  logic [SUM_W-1:0]    prod_q;
  logic [SAMPLE_W-1:0] est_q;
  logic [COUNT_W-1:0]  cnt_out_q;

  // Unit connections and combinational results.
  logic                div_start;
  logic [STEP_W-1:0]   div_steps;
  logic [SUM_W-1:0]    div_dividend;
  logic [COUNT_W-1:0]  div_divisor;
  logic                div_busy;
  logic [SUM_W-1:0]    div_quo;
  logic                sqrt_busy;
  logic [ROOT_W-1:0]   root;
  logic [SAMPLE_W:0]   diff;
  logic [SAMPLE_W:0]   ndiff;
  logic                diff_neg;
  logic [SAMPLE_W-1:0] diff_mag;
  logic [SAMPLE_W+1:0] new_mean;
  logic [SAMPLE_W-1:0] mean_clamped;
  logic [SUM_W:0]      sum_add;
  logic [SUM_W-1:0]    sum_next;
  logic                same_sign;
  logic [SAMPLE_W:0]   est_sum;

  assign sts_o.div_busy  = div_busy;
  assign sts_o.sqrt_busy = sqrt_busy;
  assign estimate_o      = est_q;
  assign sample_count_o  = cnt_out_q;

  // Signed deviation of the sample from the current mean, as sign and size.
  always_comb begin
    diff     = {1'b0, smp_q} - {1'b0, mean_q};
    ndiff    = '0 - diff;
    diff_neg = diff[SAMPLE_W];
    diff_mag = diff_neg ? ndiff[SAMPLE_W-1:0] : diff[SAMPLE_W-1:0];
  end

  // New mean from the truncated quotient, clamped to the sample range.
  always_comb begin
    if (neg_q) begin
      new_mean = {2'b00, mean_q} - {2'b00, div_quo[SAMPLE_W-1:0]};
    end else begin
      new_mean = {2'b00, mean_q} + {2'b00, div_quo[SAMPLE_W-1:0]};
    end
    if (new_mean[SAMPLE_W+1]) begin
      mean_clamped = '0;
    end else if (new_mean[SAMPLE_W]) begin
      mean_clamped = VALUE_MAX;
    end else begin
      mean_clamped = new_mean[SAMPLE_W-1:0];
    end
  end

  // Squared sum update: saturating add, or subtract clamped at zero.
  always_comb begin
    same_sign = (neg_q == dneg_q) || (mag_q == '0) || (dmag_q == '0);
    sum_add   = {1'b0, sum_q} + {1'b0, prod_q};
    if (same_sign) begin
      sum_next = sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
    end else begin
      sum_next = (prod_q >= sum_q) ? '0 : (sum_q - prod_q);
    end
  end

  // Estimate with saturation.
  assign est_sum = {1'b0, mean_q} + (SAMPLE_W + 1)'(root);

  // Divider operand selection: mean step or variance.
  always_comb begin
    div_start = cmd_i.div_mean || cmd_i.div_var;
    if (cmd_i.div_var) begin
      div_steps    = DIV_STEPS_VAR;
      div_dividend = sum_q;
      div_divisor  = count_q - 1'b1;
    end else begin
      div_steps    = DIV_STEPS_MEAN;
      div_dividend = {mag_q, {(SUM_W - SAMPLE_W){1'b0}}};
      div_divisor  = count_q;
    end
  end

  rmsd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .steps_i    (div_steps),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .busy_o     (div_busy),
    .quotient_o (div_quo)
  );

  rmsd_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.sqrt),
    .radicand_i (div_quo),
    .busy_o     (sqrt_busy),
    .root_o     (root)
  );

  // Running state; a configuration write reloads it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mean_q      <= MEAN_RESET;
      sum_q       <= '0;
      count_q     <= COUNT_ONE;
    end else begin
      if (cmd_i.cfg_load) begin
        mean_q      <= cfg_data_i;
        sum_q       <= '0;
        count_q     <= COUNT_ONE;
      end
      if (cmd_i.load && (count_q != COUNT_MAX)) begin
        count_q <= count_q + 1'b1;
      end
      if (cmd_i.mean) begin
        mean_q <= mean_clamped;
      end
      if (cmd_i.sum) begin
        sum_q <= sum_next;
      end
    end
  end

  // Working registers and the output word.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      smp_q <= sample_i;
    end
    if (cmd_i.delta) begin
      neg_q <= diff_neg;
      mag_q <= diff_mag;
    end
    if (cmd_i.dev) begin
      dneg_q <= diff_neg;
      dmag_q <= diff_mag;
    end
    if (cmd_i.mul) begin
      prod_q <= SUM_W'(mag_q) * SUM_W'(dmag_q);
    end
    if (cmd_i.result) begin
      est_q     <= est_sum[SAMPLE_W] ? VALUE_MAX : est_sum[SAMPLE_W-1:0];
      cnt_out_q <= count_q;
    end
  end

endmodule

[hw/rtl/rmsd_ctrl.sv]
// ----------------------------------------------------------------------------
// Running mean plus standard deviation: controller
// Sequences one sample through the datapath and owns the channel handshakes.
// ----------------------------------------------------------------------------
module rmsd_ctrl import rmsd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output rmsd_cmd_t cmd_o,
  input  rmsd_sts_t sts_i
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_DELTA = 4'd1;
  localparam logic [3:0] S_DIV1  = 4'd2;
  localparam logic [3:0] S_WAIT1 = 4'd3;
  localparam logic [3:0] S_MEAN  = 4'd4;
  localparam logic [3:0] S_DEV   = 4'd5;
  localparam logic [3:0] S_MUL   = 4'd6;
  localparam logic [3:0] S_SUM   = 4'd7;
  localparam logic [3:0] S_DIV2  = 4'd8;
  localparam logic [3:0] S_WAIT2 = 4'd9;
  localparam logic [3:0] S_SQRT  = 4'd10;
  localparam logic [3:0] S_WAITS = 4'd11;
  localparam logic [3:0] S_OUT   = 4'd12;

  logic [3:0] state_q;
  logic [3:0] state_d;
  logic       out_valid_q;
  logic       out_valid_d;
  logic       out_free;

  // A configuration write takes priority over a sample in the same cycle.
  assign cfg_ready_o = (state_q == S_IDLE);
  assign in_ready_o  = (state_q == S_IDLE) && !cfg_valid_i;
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        cmd_o.cfg_load = cfg_valid_i;
        cmd_o.load     = in_valid_i && in_ready_o;
        if (cmd_o.load) begin
          state_d = S_DELTA;
        end
      end
      S_DELTA: begin
        cmd_o.delta = 1'b1;
        state_d     = S_DIV1;
      end
      S_DIV1: begin
        cmd_o.div_mean = 1'b1;
        state_d        = S_WAIT1;
      end
      S_WAIT1: begin
        if (!sts_i.div_busy) begin
          state_d = S_MEAN;
        end
      end
      S_MEAN: begin
        cmd_o.mean = 1'b1;
        state_d    = S_DEV;
      end
      S_DEV: begin
        cmd_o.dev = 1'b1;
        state_d   = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum = 1'b1;
        state_d   = S_DIV2;
      end
      S_DIV2: begin
        cmd_o.div_var = 1'b1;
        state_d       = S_WAIT2;
      end
      S_WAIT2: begin
        if (!sts_i.div_busy) begin
          state_d = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd_o.sqrt = 1'b1;
        state_d    = S_WAITS;
      end
      S_WAITS: begin
        if (!sts_i.sqrt_busy) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.result = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output word valid flag.
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.result) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

[hw/rtl/running_mean_plus_stddev.sv]
// ----------------------------------------------------------------------------
// Running mean plus standard deviation
// Welford estimator over duration samples; returns mean plus deviation.
// ----------------------------------------------------------------------------
//  Channel    Direction  Word
//  sample_i   in         sample (Q8.24 seconds)
//  result_o   out        estimate (Q8.24 seconds), sample_count
//  cfg_i      in         initial_mean (reloads mean, sum and count)
//
//  From acceptance to its result word, a sample runs through the shared
//  serial divider for 32 steps for the mean and 64 for the variance, and
//  through the square root unit for 32 steps, one bit a cycle each.
//  One sample is in work at a time; the next is taken once the result word
//  is in the output register, even if that word has not been taken yet.
//  Reset loads the one millisecond mean, a zero sum and a count of one.
//  A stalled result only holds the block once the following result is due.
// ----------------------------------------------------------------------------
module running_mean_plus_stddev import rmsd_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  rmsd_sample_if.sink  sample_i,
  rmsd_result_if.source result_o,
  rmsd_cfg_if.sink     cfg_i
);

  rmsd_cmd_t cmd;
  rmsd_sts_t sts;

  // Sequencing and handshakes.
  rmsd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .cfg_valid_i (cfg_i.valid),
    .cfg_ready_o (cfg_i.ready),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Arithmetic and state.
  rmsd_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .sample_i       (sample_i.sample),
    .cfg_data_i     (cfg_i.initial_mean),
    .estimate_o     (result_o.estimate),
    .sample_count_o (result_o.sample_count)
  );

`ifndef ASSERT_OFF
  // Only one sample is in work at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_i.valid && sample_i.ready) |=> !sample_i.ready)
    else $error("sample accepted while another is in work");

  // The divider is never restarted while it is still iterating.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd.div_mean || cmd.div_var) |-> !sts.div_busy)
    else $error("divider started while busy");

  // At most one datapath command is issued per cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd))
    else $error("conflicting datapath commands");

  // A result word always reports at least one counted sample.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.sample_count != '0))
    else $error("result word with zero count");
`endif

endmodule
